/* rtl/fmipf_pkg.sv */
// fmipf_pkg: shared types and constants for the first-match address/port filter
// used by fmipf_ctrl, fmipf_dp and first_match_ip_port_filter_core
`timescale 1ns / 1ps

package fmipf_pkg;

    localparam int MAX_RULES_DEF = 64;

    localparam int OPCODE_W = 2;
    localparam int ADDR_W   = 32;
    localparam int PORT_W   = 16;

    typedef enum logic [OPCODE_W-1:0] {
        OP_CLEAR  = 2'd0,
        OP_APPEND = 2'd1,
        OP_MATCH  = 2'd2
    } t_opcode;

    // one stored rule, 51 bits
    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic [PORT_W-1:0] port;
        logic              addr_on;
        logic              port_on;
        logic              blocks;
    } t_rule;

    typedef struct packed {
        logic capture;
        logic do_clear;
        logic do_append;
        logic scan_init;
        logic scan_step;
    } t_dp_cmd;

    typedef struct packed {
        logic [OPCODE_W-1:0] opcode;
        logic                more;
        logic                hit;
    } t_dp_sts;

    typedef enum logic [1:0] {
        S_IDLE,
        S_EXEC,
        S_SCAN,
        S_RESP
    } t_state;

endpackage

/* rtl/fmipf_ctrl.sv */
// fmipf_ctrl: sequencing state machine for the filter core
// depends on fmipf_pkg; drives fmipf_dp through command and status structs
`timescale 1ns / 1ps

module fmipf_ctrl
    import fmipf_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    start,
    input  t_dp_sts i_sts,
    output t_dp_cmd o_cmd,
    output logic    busy,
    output logic    o_done
);

    t_state r_state;
    t_state n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state = r_state;
        o_cmd   = '0;
        busy    = (r_state != S_IDLE);
        o_done  = (r_state == S_RESP);
        unique case (r_state)
            S_IDLE: begin
                if (start) begin
                    o_cmd.capture = 1'b1;
                    n_state       = S_EXEC;
                end
            end
            S_EXEC: begin
                unique case (i_sts.opcode)
                    OP_CLEAR: begin
                        o_cmd.do_clear = 1'b1;
                        n_state        = S_RESP;
                    end
                    OP_APPEND: begin
                        o_cmd.do_append = 1'b1;
                        n_state         = S_RESP;
                    end
                    OP_MATCH: begin
                        o_cmd.scan_init = 1'b1;
                        n_state         = S_SCAN;
                    end
                    default: begin
                        n_state = S_RESP;
                    end
                endcase
            end
            S_SCAN: begin
                o_cmd.scan_step = 1'b1;
                // first hit decides, otherwise stop once every rule has been read
                if (i_sts.hit || !i_sts.more) begin
                    n_state = S_RESP;
                end
            end
            S_RESP: begin
                n_state = S_IDLE;
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

/* rtl/fmipf_dp.sv */
// fmipf_dp: rule memory, rule count, lookup key and result registers
// depends on fmipf_pkg; commanded by fmipf_ctrl
`timescale 1ns / 1ps

module fmipf_dp
    import fmipf_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  t_dp_cmd             i_cmd,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [ADDR_W-1:0]   i_address,
    input  logic [PORT_W-1:0]   i_port_number,
    input  logic                i_address_given,
    input  logic                i_port_given,
    input  logic                i_block_flag,
    output t_dp_sts             o_sts,
    output logic                o_allow,
    output logic                o_table_full_error
);

    localparam int CNT_W = $clog2(MAX_RULES + 1);
    localparam int IDX_W = (MAX_RULES > 1) ? $clog2(MAX_RULES) : 1;

    t_rule               r_mem [MAX_RULES];
    t_rule               r_rdata;
    t_rule               r_key;
    logic [OPCODE_W-1:0] r_op;
    logic [CNT_W-1:0]    r_count;
    logic [CNT_W-1:0]    r_rd_idx;
    logic                r_rd_vld;
    logic                r_allow;
    logic                r_full;

    logic full;
    logic more;
    logic hit;

    assign full = (r_count == CNT_W'(MAX_RULES));
    assign more = (r_rd_idx < r_count);
    assign hit  = r_rd_vld
                  && (!r_rdata.addr_on || (r_rdata.addr == r_key.addr))
                  && (!r_rdata.port_on || (r_rdata.port == r_key.port));

    assign o_sts.opcode = r_op;
    assign o_sts.more   = more;
    assign o_sts.hit    = hit;

    assign o_allow            = r_allow;
    assign o_table_full_error = r_full;

    // rule memory: one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_cmd.do_append && !full) begin
            r_mem[r_count[IDX_W-1:0]] <= r_key;
        end
        if (i_cmd.scan_step && more) begin
            r_rdata <= r_mem[r_rd_idx[IDX_W-1:0]];
        end
    end

    // transaction fields
    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op          <= i_opcode;
            r_key.addr    <= i_address;
            r_key.port    <= i_port_number;
            r_key.addr_on <= i_address_given;
            r_key.port_on <= i_port_given;
            r_key.blocks  <= i_block_flag;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count  <= '0;
            r_rd_idx <= '0;
            r_rd_vld <= 1'b0;
            r_allow  <= 1'b0;
            r_full   <= 1'b0;
        end else begin
            if (i_cmd.capture) begin
                r_allow <= 1'b0;
                r_full  <= 1'b0;
            end
            if (i_cmd.do_clear) begin
                r_count <= '0;
            end
            if (i_cmd.do_append) begin
                if (full) begin
                    r_full <= 1'b1;
                end else begin
                    r_count <= r_count + 1'b1;
                end
            end
            if (i_cmd.scan_init) begin
                r_rd_idx <= '0;
                r_rd_vld <= 1'b0;
            end
            if (i_cmd.scan_step) begin
                r_rd_vld <= more;
                if (more) begin
                    r_rd_idx <= r_rd_idx + 1'b1;
                end
                // no matching rule passes the packet
                if (hit) begin
                    r_allow <= ~r_rdata.blocks;
                end else if (!more) begin
                    r_allow <= 1'b1;
                end
            end
        end
    end

endmodule

/* rtl/first_match_ip_port_filter_core.sv */
// first_match_ip_port_filter_core: top level of the first-match address/port filter
// depends on fmipf_pkg, fmipf_ctrl and fmipf_dp
//
// channel   direction  handshake            payload
// command   in         start, busy          i_opcode i_address i_port_number
//                                           i_address_given i_port_given i_block_flag
// result    out        o_done (one cycle)   o_allow o_table_full_error
//
// a transaction is taken when start is high and busy is low; busy stays high
// until the cycle after the o_done strobe, one transaction at a time
// clear, append and unused opcodes go through S_EXEC to S_RESP, which strobes o_done
// a lookup reads the rule memory one rule a cycle from the oldest and strobes
// o_done on the first hit, or once every rule held has been read
// a synchronous reset empties the table; the receiver cannot stall results
`timescale 1ns / 1ps

module first_match_ip_port_filter_core
    import fmipf_pkg::*;
#(
    parameter int MAX_RULES = MAX_RULES_DEF
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                start,
    output logic                busy,
    input  logic [OPCODE_W-1:0] i_opcode,
    input  logic [ADDR_W-1:0]   i_address,
    input  logic [PORT_W-1:0]   i_port_number,
    input  logic                i_address_given,
    input  logic                i_port_given,
    input  logic                i_block_flag,
    output logic                o_done,
    output logic                o_allow,
    output logic                o_table_full_error
);

    t_dp_cmd cmd;
    t_dp_sts sts;

    fmipf_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .i_sts   (sts),
        .o_cmd   (cmd),
        .busy    (busy),
        .o_done  (o_done)
    );

    fmipf_dp #(
        .MAX_RULES (MAX_RULES)
    ) u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .i_opcode           (i_opcode),
        .i_address          (i_address),
        .i_port_number      (i_port_number),
        .i_address_given    (i_address_given),
        .i_port_given       (i_port_given),
        .i_block_flag       (i_block_flag),
        .o_sts              (sts),
        .o_allow            (o_allow),
        .o_table_full_error (o_table_full_error)
    );

endmodule
